FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SRF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: hdl/srf_pkg.sv
package srf_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 6;

   typedef enum logic [1:0] {
      KIND_ASH = 2'd0,
      KIND_LSH = 2'd1,
      KIND_ROX = 2'd2,
      KIND_ROT = 2'd3
   } kind_type;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   // outcome of one single-bit step
   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic              c;
      logic              x;
      logic              v;
   } step_type;

   function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
      logic [DATA_W-1:0] m;
      case (size)
         SIZE_BYTE: m = DATA_W'(32'h0000_00FF);
         SIZE_WORD: m = DATA_W'(32'h0000_FFFF);
         default:   m = '1;
      endcase
      return m;
   endfunction

   function automatic logic [DATA_W-1:0] sign_mask(input logic [1:0] size);
      logic [DATA_W-1:0] s;
      case (size)
         SIZE_BYTE: s = DATA_W'(32'h0000_0080);
         SIZE_WORD: s = DATA_W'(32'h0000_8000);
         default:   s = {1'b1, {(DATA_W-1){1'b0}}};
      endcase
      return s;
   endfunction

endpackage

FILE: hdl/shift_rotate_unit_with_flags.sv
// The shared one-bit shifter moves one position per cycle, and the unit takes no new
// word until the result is taken.
// Reset (synchronous, active high): sequencer returns to idle, no result pending.
`include "assert_macros.svh"

module shift_rotate_unit_with_flags import srf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_kind,
   input  logic              req_left,
   input  logic [1:0]        req_size,
   input  logic [CNT_W-1:0]  req_count,
   input  logic [DATA_W-1:0] req_value,
   input  logic              req_x_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [DATA_W-1:0] rsp_result,
   output logic              rsp_carry,
   output logic              rsp_extend,
   output logic              rsp_overflow,
   output logic              rsp_negative,
   output logic              rsp_zero
);

   // Sequencer: idle -> run (one step per cycle) -> done (hold result word).
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] word_ff, word_in;
   kind_type          kind_ff, kind_in;
   logic              left_ff, left_in;
   logic [1:0]        size_ff, size_in;
   logic              orig_sign_ff, orig_sign_in;
   logic              c_ff, c_in;
   logic              x_ff, x_in;
   logic              v_ff, v_in;

   logic              accept;
   logic [DATA_W-1:0] load_word;
   kind_type          req_kind_t;
   step_type          step;

   assign accept     = req_valid && !req_stall;
   assign req_kind_t = kind_type'(req_kind);
   assign load_word  = req_value & size_mask(req_size);

   // Shared one-bit shift unit, fed from the working registers.
   srf_step u_step (
      .cur       (word_ff),
      .kind      (kind_ff),
      .left      (left_ff),
      .size      (size_ff),
      .x         (x_ff),
      .orig_sign (orig_sign_ff),
      .nxt       (step)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      word_in      = word_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      size_in      = size_ff;
      orig_sign_in = orig_sign_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      v_in         = v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // Load operand at its size; a zero count goes straight to done.
               word_in      = load_word;
               kind_in      = req_kind_t;
               left_in      = req_left;
               size_in      = req_size;
               cnt_in       = req_count;
               orig_sign_in = |(load_word & sign_mask(req_size));
               x_in         = req_x_in;
               // rotate through extend reports X as carry on a zero count
               c_in         = (req_kind_t == KIND_ROX) ? req_x_in : 1'b0;
               v_in         = 1'b0;
               state_in     = (req_count == '0) ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            // Advance one bit position; overflow is sticky.
            word_in = step.word;
            c_in    = step.c;
            x_in    = step.x;
            v_in    = v_ff | step.v;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold the result word until the consumer takes it.
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         kind_ff  <= KIND_ASH;
         left_ff  <= 1'b0;
         v_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         v_ff     <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      size_ff      <= size_in;
      orig_sign_ff <= orig_sign_in;
      c_ff         <= c_in;
      x_ff         <= x_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_DONE);
   assign rsp_result   = word_ff;
   assign rsp_carry    = c_ff;
   assign rsp_extend   = x_ff;
   assign rsp_overflow = v_ff;
   assign rsp_negative = |(word_ff & sign_mask(size_ff));
   assign rsp_zero     = (word_ff == '0);

   `SRF_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "sequencer not idle after reset")
   `SRF_ASSERT(a_no_take_when_busy, rsp_valid |-> req_stall, "input taken while result pending")
   `SRF_ASSERT(a_run_count_live, (state_ff == ST_RUN) |-> (cnt_ff != '0), "step loop with zero count")
   `SRF_ASSERT(a_rot_keeps_x, ((state_ff == ST_RUN) && (kind_ff == KIND_ROT)) |=> $stable(x_ff), "rotate changed extend")
   `SRF_ASSERT(a_v_only_asl, v_ff |-> ((kind_ff == KIND_ASH) && left_ff), "overflow outside arithmetic left shift")

endmodule

FILE: hdl/srf_step.sv
// One bit position of shift or rotate, with carry, extend and overflow.
module srf_step import srf_pkg::*; (
   input  logic [DATA_W-1:0] cur,
   input  kind_type          kind,
   input  logic              left,
   input  logic [1:0]        size,
   input  logic              x,
   input  logic              orig_sign,
   output step_type          nxt
);

   logic [DATA_W-1:0] m;
   logic [DATA_W-1:0] sg;
   logic              msb;
   logic              lsb;
   logic [DATA_W-1:0] raw;
   logic              fill;

   assign m   = size_mask(size);
   assign sg  = sign_mask(size);
   assign msb = |(cur & sg);
   assign lsb = cur[0];

   always_comb begin
      case (kind)
         KIND_ASH: fill = left ? 1'b0 : msb;
         KIND_LSH: fill = 1'b0;
         KIND_ROX: fill = x;
         KIND_ROT: fill = left ? msb : lsb;
         default:  fill = 1'b0;
      endcase
   end

   always_comb begin
      if (left) begin
         raw = {cur[DATA_W-2:0], fill};
      end else begin
         raw = (cur >> 1) | (fill ? sg : '0);
      end
      nxt.word = raw & m;
      nxt.c    = left ? msb : lsb;
      // plain rotate leaves extend alone
      nxt.x    = (kind == KIND_ROT) ? x : nxt.c;
      nxt.v    = (kind == KIND_ASH) && left && ((|(nxt.word & sg)) != orig_sign);
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import srf_pkg::*;

   // The package names byte and word sizes only; long is the remaining legal code.
   localparam logic [1:0] SIZE_LONG = 2'd2;

   // Slowest item is count 63 plus setup; leave room for the tail of the run.
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_REPORTS  = 10;

   // One expected result word: the shifted value and the five flags.
   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              carry;
      logic              extend;
      logic              overflow;
      logic              negative;
      logic              zero;
   } shift_flags_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_kind;
   logic              req_left;
   logic [1:0]        req_size;
   logic [CNT_W-1:0]  req_count;
   logic [DATA_W-1:0] req_value;
   logic              req_x_in;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [DATA_W-1:0] rsp_result;
   logic              rsp_carry;
   logic              rsp_extend;
   logic              rsp_overflow;
   logic              rsp_negative;
   logic              rsp_zero;

   // Results the unit still owes us, oldest first.
   shift_flags_type pending_flags[$];

   int  words_sent;
   int  words_checked;
   int  mismatches;
   bit  tx_idle;        // sender inserts random gaps
   bit  rx_idle;        // receiver inserts random stalls
   int  rx_hold_cycles; // one long receiver hold-off, consumed by the receiver

   shift_rotate_unit_with_flags dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_left     (req_left),
      .req_size     (req_size),
      .req_count    (req_count),
      .req_value    (req_value),
      .req_x_in     (req_x_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result   (rsp_result),
      .rsp_carry    (rsp_carry),
      .rsp_extend   (rsp_extend),
      .rsp_overflow (rsp_overflow),
      .rsp_negative (rsp_negative),
      .rsp_zero     (rsp_zero)
   );

   // 20 ns period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Predict one operation by walking it one bit position at a time,
   // exactly as the 68000 defines the flags.
   function automatic shift_flags_type predict_shift(input kind_type kind, input logic left,
                                                     input logic [1:0] size,
                                                     input logic [CNT_W-1:0] count,
                                                     input logic [DATA_W-1:0] value,
                                                     input logic x_in);
      logic [DATA_W-1:0] msk;
      logic [DATA_W-1:0] sgn;
      logic [DATA_W-1:0] r;
      logic [DATA_W-1:0] orig_sign;
      logic              c;
      logic              x;
      logic              v;
      logic              msb;
      logic              lsb;
      shift_flags_type   p;
      case (size)
         SIZE_BYTE: begin
            msk = 32'h0000_00FF;
            sgn = 32'h0000_0080;
         end
         SIZE_WORD: begin
            msk = 32'h0000_FFFF;
            sgn = 32'h0000_8000;
         end
         default: begin
            msk = 32'hFFFF_FFFF;
            sgn = 32'h8000_0000;
         end
      endcase
      r = value & msk;
      orig_sign = r & sgn;
      x = x_in;
      v = 1'b0;
      // Zero count leaves the operand alone; only ROXL/ROXR copy X into C.
      c = (count == 0 && kind == KIND_ROX) ? x_in : 1'b0;
      for (int i = 0; i < count; i++) begin
         msb = |(r & sgn);
         lsb = r[0];
         c = left ? msb : lsb;
         case (kind)
            KIND_ASH: begin
               if (left) begin
                  r = (r << 1) & msk;
                  // V sticks once the sign bit has differed at any step.
                  if ((r & sgn) != orig_sign) v = 1'b1;
               end else begin
                  r = ((r >> 1) | (r & sgn)) & msk;
               end
               x = c;
            end
            KIND_LSH: begin
               r = left ? ((r << 1) & msk) : ((r >> 1) & msk);
               x = c;
            end
            KIND_ROX: begin
               if (left) r = ((r << 1) | {31'b0, x}) & msk;
               else      r = ((r >> 1) | (x ? sgn : '0)) & msk;
               x = c;
            end
            default: begin
               // Plain rotate never touches X.
               if (left) r = ((r << 1) | {31'b0, msb}) & msk;
               else      r = ((r >> 1) | (lsb ? sgn : '0)) & msk;
            end
         endcase
      end
      p.result   = r;
      p.carry    = c;
      p.extend   = x;
      p.overflow = v;
      p.negative = |(r & sgn);
      p.zero     = (r == '0);
      return p;
   endfunction

   // Offer one word on the request side: optional gap, then hold it until taken.
   // Valid stays high straight into the next word when there is no gap.
   task automatic send_word(input kind_type kind, input logic left, input logic [1:0] size,
                            input logic [CNT_W-1:0] count, input logic [DATA_W-1:0] value,
                            input logic x_in);
      int gap;
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind  <= kind;
      req_left  <= left;
      req_size  <= size;
      req_count <= count;
      req_value <= value;
      req_x_in  <= x_in;
      req_valid <= 1'b1;
      // Hold the payload steady until an edge sees it accepted.
      do @(posedge clock); while (req_stall);
      pending_flags.push_back(predict_shift(kind, left, size, count, value, x_in));
      words_sent++;
      @(negedge clock);
   endtask

   // Draw an operand that favors the interesting corners of each size.
   function automatic logic [DATA_W-1:0] pick_value(input logic [1:0] size);
      logic [DATA_W-1:0] sgn;
      sgn = (size == SIZE_BYTE) ? 32'h80 : (size == SIZE_WORD) ? 32'h8000 : 32'h8000_0000;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return sgn;
         3:       return sgn - 1;
         default: return $urandom;
      endcase
   endfunction

   // Draw a count: mostly short, some whole multiples of the width, some anywhere.
   function automatic logic [CNT_W-1:0] pick_count(input logic [1:0] size);
      int width;
      width = (size == SIZE_BYTE) ? 8 : (size == SIZE_WORD) ? 16 : 32;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return CNT_W'($urandom_range(0, 8));
         5:             return CNT_W'(width * $urandom_range(1, 63 / width));
         default:       return CNT_W'($urandom_range(0, 63));
      endcase
   endfunction

   task automatic send_random_word;
      logic [1:0] size;
      size = 2'($urandom_range(0, 2));
      send_word(kind_type'(2'($urandom_range(0, 3))), 1'($urandom_range(0, 1)), size,
                pick_count(size), pick_value(size), 1'($urandom_range(0, 1)));
   endtask

   // Corners: every kind both ways, zero counts, whole-width rotates,
   // counts past the width, V on ASL, the memory form, junk in upper bits.
   task automatic test_directed;
      send_word(KIND_ASH, 1'b1, SIZE_WORD, 6'd1,  32'h0000_4000, 1'b0);
      send_word(KIND_ASH, 1'b1, SIZE_BYTE, 6'd0,  32'h0000_00FF, 1'b1);
      send_word(KIND_ROX, 1'b1, SIZE_BYTE, 6'd0,  32'h0000_0000, 1'b1);
      send_word(KIND_ROX, 1'b0, SIZE_LONG, 6'd0,  32'hDEAD_BEEF, 1'b0);
      send_word(KIND_ROT, 1'b1, SIZE_BYTE, 6'd8,  32'h0000_0081, 1'b1);
      send_word(KIND_ROT, 1'b0, SIZE_WORD, 6'd16, 32'h0000_8001, 1'b0);
      send_word(KIND_ROT, 1'b0, SIZE_LONG, 6'd32, 32'h8000_0000, 1'b0);
      send_word(KIND_ROT, 1'b1, SIZE_LONG, 6'd63, 32'hA5C3_0F96, 1'b1);
      send_word(KIND_LSH, 1'b0, SIZE_LONG, 6'd63, 32'hFFFF_FFFF, 1'b0);
      send_word(KIND_ASH, 1'b0, SIZE_LONG, 6'd63, 32'h8000_0000, 1'b0);
      send_word(KIND_ASH, 1'b0, SIZE_BYTE, 6'd1,  32'h0000_0080, 1'b1);
      send_word(KIND_ASH, 1'b1, SIZE_LONG, 6'd40, 32'h1234_5678, 1'b0);
      send_word(KIND_ASH, 1'b1, SIZE_BYTE, 6'd2,  32'h0000_00E0, 1'b0);
      send_word(KIND_LSH, 1'b1, SIZE_WORD, 6'd1,  32'h0000_8000, 1'b0);
      send_word(KIND_LSH, 1'b0, SIZE_BYTE, 6'd7,  32'hFFFF_FF81, 1'b1);
      send_word(KIND_ROX, 1'b1, SIZE_BYTE, 6'd9,  32'h0000_005A, 1'b1);
      send_word(KIND_ROX, 1'b0, SIZE_WORD, 6'd17, 32'h0000_1234, 1'b0);
      send_word(KIND_ROX, 1'b1, SIZE_LONG, 6'd33, 32'hFFFF_FFFF, 1'b0);
      send_word(KIND_ROT, 1'b0, SIZE_BYTE, 6'd3,  32'h0000_0000, 1'b1);
      send_word(KIND_LSH, 1'b1, SIZE_LONG, 6'd31, 32'h0000_0001, 1'b1);
      send_word(KIND_ASH, 1'b0, SIZE_WORD, 6'd0,  32'h0000_8000, 1'b1);
      send_word(KIND_ROX, 1'b0, SIZE_BYTE, 6'd1,  32'h0000_0001, 1'b1);
      send_word(KIND_ASH, 1'b1, SIZE_LONG, 6'd1,  32'h7FFF_FFFF, 1'b0);
   endtask

   // Receiver parks for a long stretch while the sender keeps offering words
   // back to back, so the unit fills up and pushes back on its input.
   task automatic test_backpressure;
      tx_idle = 1'b0;
      rx_hold_cycles = 300;
      repeat (15) send_random_word();
      tx_idle = 1'b1;
   endtask

   // Both sides run flat out: no gaps, no stalls.
   task automatic test_full_rate;
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      repeat (150) send_random_word();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_random;
      repeat (1060) send_random_word();
   endtask

   // Stall pattern on the result side: per word draw a hold-off, then accept.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
         end else begin
            n = rx_idle ? $urandom_range(0, 10) : 0;
         end
         rsp_stall <= (n != 0);
         if (n != 0) begin
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Compare each taken result word against the oldest prediction.
   always @(posedge clock) begin
      shift_flags_type exp_word;
      shift_flags_type got_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         got_word = '{rsp_result, rsp_carry, rsp_extend, rsp_overflow, rsp_negative, rsp_zero};
         if (pending_flags.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected result word %h (no prediction waiting)",
                        $time, got_word.result);
         end else begin
            exp_word = pending_flags.pop_front();
            words_checked++;
            if (got_word.result   !== exp_word.result   ||
                got_word.carry    !== exp_word.carry    ||
                got_word.extend   !== exp_word.extend   ||
                got_word.overflow !== exp_word.overflow ||
                got_word.negative !== exp_word.negative ||
                got_word.zero     !== exp_word.zero) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch exp %h C%b X%b V%b N%b Z%b, got %h C%b X%b V%b N%b Z%b",
                           $time, exp_word.result, exp_word.carry, exp_word.extend,
                           exp_word.overflow, exp_word.negative, exp_word.zero,
                           got_word.result, got_word.carry, got_word.extend,
                           got_word.overflow, got_word.negative, got_word.zero);
            end
         end
      end
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      // Drive every input to a known value from time zero.
      reset     = 1'b1;
      req_valid = 1'b0;
      req_kind  = KIND_ASH;
      req_left  = 1'b0;
      req_size  = SIZE_BYTE;
      req_count = '0;
      req_value = '0;
      req_x_in  = 1'b0;
      words_sent = 0;
      words_checked = 0;
      mismatches = 0;
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      rx_hold_cycles = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_full_rate();
      test_random();

      // Drop valid, drain what is owed, then give stray words time to show up.
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_flags.size() != 0) mismatches++;

      $display("Sent %0d operand words and checked %0d result words, %0d mismatches.",
               words_sent, words_checked, mismatches);
      $display("Covered all four shift kinds both ways, byte/word/long, counts 0 to 63, stalls.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
